[src/assert_macros.svh]
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AST_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ugfrx_pkg.sv]
`default_nettype none

package ugfrx_pkg;

    localparam int RX_DEPTH_DEF = 32;
    localparam int TX_DEPTH_DEF = 32;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int GAP_W   = 8;
    localparam int LEN_W   = 6;

    // register index decode on paddr[2]
    localparam logic [0:0] REG_GAP = 1'b0;
    localparam logic [GAP_W-1:0] GAP_RESET = 8'd5;

    typedef enum logic [2:0] {
        OP_RX_BYTE  = 3'd0,
        OP_TICK     = 3'd1,
        OP_RELEASE  = 3'd2,
        OP_TX_LOAD  = 3'd3,
        OP_TX_READY = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_BUSY = 2'd1,
        RX_DONE = 2'd2,
        RX_PROC = 2'd3
    } t_rx_mode;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_TX     = 2'd1;
    localparam logic [1:0] KIND_RX     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STAT,
        S_TX_RD,
        S_TX_OUT,
        S_REL_OUT
    } t_ctrl_state;

    typedef struct packed {
        logic accept;
        logic tx_rd;
        logic load_stat;
        logic load_tx;
        logic load_rel;
    } t_dp_cmd;

    typedef struct packed {
        logic go_tx;
        logic go_rel;
        logic rel_more;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[src/ugfrx_ram.sv]
`default_nettype none

module ugfrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/ugfrx_dp.sv]
`default_nettype none

module ugfrx_dp #(
    parameter int RX_DEPTH = ugfrx_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = ugfrx_pkg::TX_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ugfrx_pkg::t_dp_cmd          i_cmd,
    output ugfrx_pkg::t_dp_status            o_status,
    input  wire logic [2:0]                  i_operation,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic                        i_load_last,
    input  wire logic                        i_cfg_we,
    input  wire logic [ugfrx_pkg::GAP_W-1:0] i_cfg_wdata,
    output logic      [ugfrx_pkg::GAP_W-1:0] o_gap_ticks_max,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic      [1:0]                  o_kind,
    output logic      [7:0]                  o_out_byte,
    output logic                             o_frame_last,
    output logic      [1:0]                  o_rx_state,
    output logic                             o_tx_busy,
    output logic      [ugfrx_pkg::LEN_W-1:0] o_rx_length
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);

    logic [ugfrx_pkg::GAP_W-1:0] r_gap;
    logic [RX_CW-1:0]            r_fill, n_fill;
    ugfrx_pkg::t_rx_mode         r_mode, n_mode;
    logic [7:0]                  r_silence, n_silence;
    logic [TX_CW-1:0]            r_load_pos, n_load_pos;
    logic [TX_CW-1:0]            r_tx_len, n_tx_len;
    logic [TX_CW-1:0]            r_tx_pos, n_tx_pos;
    logic                        r_sending, n_sending;
    logic [RX_CW-1:0]            r_rel_cnt, n_rel_cnt;
    logic [RX_AW-1:0]            r_rel_idx, n_rel_idx;
    logic [TX_AW-1:0]            r_tx_addr, n_tx_addr;

    logic                        r_out_valid;
    logic [1:0]                  r_out_kind;
    logic [7:0]                  r_out_byte;
    logic                        r_out_last;
    logic [1:0]                  r_out_rx_state;
    logic                        r_out_tx_busy;
    logic [ugfrx_pkg::LEN_W-1:0] r_out_rx_len;

    ugfrx_pkg::t_op              op;
    logic                        rx_room, tx_room, rel_more, go_tx, go_rel;
    logic                        rx_we, tx_we, rx_re;
    logic [RX_CW-1:0]            rel_idx_next;
    logic [TX_CW-1:0]            load_next;
    logic [RX_AW-1:0]            rx_raddr;
    logic [7:0]                  rx_rdata, tx_rdata;

    assign op           = ugfrx_pkg::t_op'(i_operation);
    assign rx_room      = r_fill < RX_CW'(RX_DEPTH);
    assign tx_room      = r_load_pos < TX_CW'(TX_DEPTH);
    assign load_next    = tx_room ? r_load_pos + TX_CW'(1) : r_load_pos;
    assign rel_idx_next = RX_CW'(r_rel_idx) + RX_CW'(1);
    assign rel_more     = rel_idx_next < r_rel_cnt;

    always_comb begin
        n_fill     = r_fill;
        n_mode     = r_mode;
        n_silence  = r_silence;
        n_load_pos = r_load_pos;
        n_tx_len   = r_tx_len;
        n_tx_pos   = r_tx_pos;
        n_sending  = r_sending;
        n_rel_cnt  = r_rel_cnt;
        n_tx_addr  = r_tx_addr;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        go_tx      = 1'b0;
        go_rel     = 1'b0;
        unique case (op)
            ugfrx_pkg::OP_RX_BYTE: begin
                // bytes are ignored while a finished frame waits for release
                if (r_mode != ugfrx_pkg::RX_DONE) begin
                    n_silence = '0;
                    n_mode    = ugfrx_pkg::RX_BUSY;
                    if (rx_room) begin
                        rx_we  = 1'b1;
                        n_fill = r_fill + RX_CW'(1);
                    end
                end
            end
            ugfrx_pkg::OP_TICK: begin
                if (r_silence <= r_gap) begin
                    if (r_silence != 8'hFF) begin
                        n_silence = r_silence + 8'd1;
                    end
                end else if (r_mode == ugfrx_pkg::RX_BUSY) begin
                    n_mode = ugfrx_pkg::RX_DONE;
                end
            end
            ugfrx_pkg::OP_RELEASE: begin
                if (r_mode == ugfrx_pkg::RX_DONE) begin
                    n_fill    = '0;
                    n_mode    = ugfrx_pkg::RX_PROC;
                    n_rel_cnt = r_fill;
                    go_rel    = r_fill != '0;
                end
            end
            ugfrx_pkg::OP_TX_LOAD: begin
                if (!r_sending) begin
                    tx_we = tx_room;
                    if (i_load_last) begin
                        n_tx_len   = load_next;
                        n_load_pos = '0;
                        n_sending  = 1'b1;
                        n_tx_pos   = TX_CW'(1);
                        n_tx_addr  = '0;
                        go_tx      = 1'b1;
                    end else begin
                        n_load_pos = load_next;
                    end
                end
            end
            ugfrx_pkg::OP_TX_READY: begin
                if (r_sending) begin
                    if (r_tx_pos < r_tx_len) begin
                        n_tx_addr = r_tx_pos[TX_AW-1:0];
                        n_tx_pos  = r_tx_pos + TX_CW'(1);
                        go_tx     = 1'b1;
                    end else begin
                        n_sending = 1'b0;
                        n_tx_pos  = TX_CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // release walk: index 0 is read on accept, the next one on each load
    always_comb begin
        n_rel_idx = r_rel_idx;
        rx_raddr  = rel_idx_next[RX_AW-1:0];
        rx_re     = 1'b0;
        if (i_cmd.accept) begin
            n_rel_idx = '0;
            rx_raddr  = '0;
            rx_re     = go_rel;
        end else if (i_cmd.load_rel && rel_more) begin
            n_rel_idx = rel_idx_next[RX_AW-1:0];
            rx_re     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap      <= ugfrx_pkg::GAP_RESET;
            r_fill     <= '0;
            r_mode     <= ugfrx_pkg::RX_IDLE;
            r_silence  <= '0;
            r_load_pos <= '0;
            r_tx_len   <= '0;
            r_tx_pos   <= '0;
            r_sending  <= 1'b0;
            r_rel_cnt  <= '0;
            r_rel_idx  <= '0;
            r_tx_addr  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gap <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_fill     <= n_fill;
                r_mode     <= n_mode;
                r_silence  <= n_silence;
                r_load_pos <= n_load_pos;
                r_tx_len   <= n_tx_len;
                r_tx_pos   <= n_tx_pos;
                r_sending  <= n_sending;
                r_rel_cnt  <= n_rel_cnt;
                r_tx_addr  <= n_tx_addr;
            end
            r_rel_idx <= n_rel_idx;
        end
    end

    ugfrx_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && rx_we),
        .i_waddr (r_fill[RX_AW-1:0]),
        .i_wdata (i_data_byte),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    ugfrx_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && tx_we),
        .i_waddr (r_load_pos[TX_AW-1:0]),
        .i_wdata (i_data_byte),
        .i_re    (i_cmd.tx_rd),
        .i_raddr (r_tx_addr),
        .o_rdata (tx_rdata)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_stat || i_cmd.load_tx || i_cmd.load_rel) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load_stat) begin
            r_out_kind <= ugfrx_pkg::KIND_STATUS;
            r_out_byte <= '0;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_tx) begin
            r_out_kind <= ugfrx_pkg::KIND_TX;
            r_out_byte <= tx_rdata;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_rel) begin
            r_out_kind <= ugfrx_pkg::KIND_RX;
            r_out_byte <= rx_rdata;
            r_out_last <= !rel_more;
        end else begin
            r_out_kind <= r_out_kind;
            r_out_byte <= r_out_byte;
            r_out_last <= r_out_last;
        end
        if (i_cmd.load_stat || i_cmd.load_tx || i_cmd.load_rel) begin
            r_out_rx_state <= r_mode;
            r_out_tx_busy  <= r_sending;
            r_out_rx_len   <= ugfrx_pkg::LEN_W'(r_fill);
        end
    end

    assign o_status.go_tx    = go_tx;
    assign o_status.go_rel   = go_rel;
    assign o_status.rel_more = rel_more;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_gap_ticks_max = r_gap;
    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_out_byte      = r_out_byte;
    assign o_frame_last    = r_out_last;
    assign o_rx_state      = r_out_rx_state;
    assign o_tx_busy       = r_out_tx_busy;
    assign o_rx_length     = r_out_rx_len;

endmodule

`default_nettype wire

[src/ugfrx_ctrl.sv]
`default_nettype none

module ugfrx_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire ugfrx_pkg::t_dp_status  i_status,
    output ugfrx_pkg::t_dp_cmd          o_cmd
);

    ugfrx_pkg::t_ctrl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ugfrx_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ugfrx_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    priority if (i_status.go_rel) begin
                        n_state = ugfrx_pkg::S_REL_OUT;
                    end else if (i_status.go_tx) begin
                        n_state = ugfrx_pkg::S_TX_RD;
                    end else begin
                        n_state = ugfrx_pkg::S_STAT;
                    end
                end
            end
            ugfrx_pkg::S_STAT: begin
                if (i_status.out_free) begin
                    o_cmd.load_stat = 1'b1;
                    n_state         = ugfrx_pkg::S_IDLE;
                end
            end
            ugfrx_pkg::S_TX_RD: begin
                o_cmd.tx_rd = 1'b1;
                n_state     = ugfrx_pkg::S_TX_OUT;
            end
            ugfrx_pkg::S_TX_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_tx = 1'b1;
                    n_state       = ugfrx_pkg::S_IDLE;
                end
            end
            ugfrx_pkg::S_REL_OUT: begin
                // one stored byte per free output slot
                if (i_status.out_free) begin
                    o_cmd.load_rel = 1'b1;
                    if (!i_status.rel_more) begin
                        n_state = ugfrx_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = ugfrx_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[src/uart_gap_framed_rx_and_frame_tx.sv]
// channel | direction | handshake                      | payload
// input   | in        | i_in_valid / o_in_ready        | i_operation, i_data_byte, i_load_last
// output  | out       | o_out_valid / i_out_ready      | o_kind, o_out_byte, o_frame_last,
//         |           |                                | o_rx_state, o_tx_busy, o_rx_length
// config  | in        | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// a status-only word is accepted in idle and its result loaded once the output is free;
// a transmit byte adds a read state for the registered read of the transmit buffer.
// a frame release streams the stored bytes from the receive buffer read port,
// one byte per free output slot.
// reset is synchronous and active low; both buffers need no clearing pass.
// a stalled output holds its word; the next word is accepted once the result is loaded.
`default_nettype none

module uart_gap_framed_rx_and_frame_tx #(
    parameter int RX_DEPTH = ugfrx_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = ugfrx_pkg::TX_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [2:0]                    i_operation,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_load_last,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [1:0]                    o_kind,
    output logic      [7:0]                    o_out_byte,
    output logic                               o_frame_last,
    output logic      [1:0]                    o_rx_state,
    output logic                               o_tx_busy,
    output logic      [ugfrx_pkg::LEN_W-1:0]   o_rx_length,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ugfrx_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ugfrx_pkg::PDATA_W-1:0] pwdata,
    output logic      [ugfrx_pkg::PDATA_W-1:0] prdata,
    output logic                               pready
);

    ugfrx_pkg::t_dp_cmd          cmd;
    ugfrx_pkg::t_dp_status       status;
    logic                        cfg_sel;
    logic [ugfrx_pkg::GAP_W-1:0] gap;

    assign pready  = 1'b1;
    assign cfg_sel = paddr[ugfrx_pkg::PADDR_W-1:2] == ugfrx_pkg::REG_GAP;
    assign prdata  = cfg_sel ? ugfrx_pkg::PDATA_W'(gap) : '0;

    ugfrx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ugfrx_dp #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .i_load_last     (i_load_last),
        .i_cfg_we        (psel && penable && pwrite && pready && cfg_sel),
        .i_cfg_wdata     (pwdata[ugfrx_pkg::GAP_W-1:0]),
        .o_gap_ticks_max (gap),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_out_byte      (o_out_byte),
        .o_frame_last    (o_frame_last),
        .o_rx_state      (o_rx_state),
        .o_tx_busy       (o_tx_busy),
        .o_rx_length     (o_rx_length)
    );

endmodule

`default_nettype wire

[src/ugfrx_chk.sv]
`default_nettype none
`include "assert_macros.svh"

module ugfrx_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [1:0]                  o_kind,
    input wire logic [7:0]                  o_out_byte,
    input wire logic                        o_frame_last,
    input wire logic [1:0]                  o_rx_state,
    input wire logic                        o_tx_busy,
    input wire logic [ugfrx_pkg::LEN_W-1:0] o_rx_length
);

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kind) && $stable(o_out_byte) && $stable(o_frame_last), "stalled output word changed")

    `AST_SAME(a_status_word, i_clk, i_rst_n, o_out_valid && o_kind == ugfrx_pkg::KIND_STATUS, o_out_byte == 8'd0 && o_frame_last, "status word carries a byte or misses last")

    `AST_SAME(a_tx_busy, i_clk, i_rst_n, o_out_valid && o_kind == ugfrx_pkg::KIND_TX, o_tx_busy && o_frame_last, "transmit byte sent while transmitter idle")

    `AST_SAME(a_rel_state, i_clk, i_rst_n, o_out_valid && o_kind == ugfrx_pkg::KIND_RX, o_rx_state == ugfrx_pkg::RX_PROC && o_rx_length == '0, "released byte without processed frame state")

endmodule

bind uart_gap_framed_rx_and_frame_tx ugfrx_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_out_byte   (o_out_byte),
    .o_frame_last (o_frame_last),
    .o_rx_state   (o_rx_state),
    .o_tx_busy    (o_tx_busy),
    .o_rx_length  (o_rx_length)
);

`default_nettype wire

[tb/uart_gap_framed_rx_and_frame_tx_tb.sv]
`default_nettype none

module uart_gap_framed_rx_and_frame_tx_tb;

    localparam int RX_DEPTH = ugfrx_pkg::RX_DEPTH_DEF;
    localparam int TX_DEPTH = ugfrx_pkg::TX_DEPTH_DEF;
    localparam int LEN_W = ugfrx_pkg::LEN_W;
    localparam int PADDR_W = ugfrx_pkg::PADDR_W;
    localparam int PDATA_W = ugfrx_pkg::PDATA_W;
    localparam logic [PADDR_W-1:0] ADDR_GAP = {ugfrx_pkg::REG_GAP, 2'b00};
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic [7:0] GAP_FLOOR = 8'd0;
    localparam logic [7:0] GAP_CEIL = 8'd254;
    localparam int CEIL_TICKS = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PAD = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       out_byte;
        logic             frame_last;
        logic [1:0]       rx_state;
        logic             tx_busy;
        logic [LEN_W-1:0] rx_length;
    } t_response;

    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        logic       last;
        int         reps;
        bit         rnd;
        bit         typed;
        t_response  want;
    } t_step_row;

    typedef enum {ST_OPEN, ST_COIN, ST_CADENCE, ST_SPARSE} t_stall_style;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [2:0] i_operation;
    logic [7:0] i_data_byte;
    logic i_load_last;
    logic o_out_valid;
    logic i_out_ready;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic o_frame_last;
    logic [1:0] o_rx_state;
    logic o_tx_busy;
    logic [LEN_W-1:0] o_rx_length;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    uart_gap_framed_rx_and_frame_tx dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_data_byte  (i_data_byte),
        .i_load_last  (i_load_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_frame_last (o_frame_last),
        .o_rx_state   (o_rx_state),
        .o_tx_busy    (o_tx_busy),
        .o_rx_length  (o_rx_length),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the block state
    logic [7:0]          gap_limit;
    logic [7:0]          rx_mem [RX_DEPTH];
    int                  rx_cnt;
    ugfrx_pkg::t_rx_mode rx_phase;
    logic [7:0]          quiet_ticks;
    logic [7:0]          tx_mem [TX_DEPTH];
    int                  tx_wr;
    int                  tx_total;
    int                  tx_rd;
    logic                tx_active;

    t_response  due_responses[$];
    t_step_row  directed_plan[$];
    int         mismatches = 0;
    int         words_sent = 0;
    int         responses_checked = 0;
    int         burst_left = 0;
    bit         offering = 1'b0;
    bit         hold_req = 1'b0;
    t_response  seen;
    t_response  owed;

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    function automatic t_response status_only(input ugfrx_pkg::t_rx_mode st,
                                              input logic busy, input int len);
        t_response r;
        r = '0;
        r.kind = ugfrx_pkg::KIND_STATUS;
        r.frame_last = 1'b1;
        r.rx_state = st;
        r.tx_busy = busy;
        r.rx_length = LEN_W'(len);
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] op, input logic [7:0] data,
                                    input logic last, input int reps,
                                    input int rnd, input int typed,
                                    input t_response want);
        t_step_row row;
        row.op = op;
        row.data = data;
        row.last = last;
        row.reps = reps;
        row.rnd = (rnd != 0);
        row.typed = (typed != 0);
        row.want = want;
        directed_plan.push_back(row);
    endfunction

    // advances the shadow state by one word and queues what the block must answer
    function automatic void derive_responses(input logic [2:0] op, input logic [7:0] b,
                                             input logic last);
        t_response resp;
        t_response item;
        t_response burst[$];
        int i;
        resp = '0;
        resp.kind = ugfrx_pkg::KIND_STATUS;
        resp.frame_last = 1'b1;
        case (op)
            ugfrx_pkg::OP_RX_BYTE: begin
                if (rx_phase != ugfrx_pkg::RX_DONE) begin
                    quiet_ticks = 8'd0;
                    rx_phase = ugfrx_pkg::RX_BUSY;
                    if (rx_cnt < RX_DEPTH) begin
                        rx_mem[rx_cnt] = b;
                        rx_cnt++;
                    end
                end
            end
            ugfrx_pkg::OP_TICK: begin
                if (quiet_ticks <= gap_limit) begin
                    if (quiet_ticks != 8'hFF) quiet_ticks++;
                end else if (rx_phase == ugfrx_pkg::RX_BUSY) begin
                    rx_phase = ugfrx_pkg::RX_DONE;
                end
            end
            ugfrx_pkg::OP_RELEASE: begin
                if (rx_phase == ugfrx_pkg::RX_DONE) begin
                    for (i = 0; i < rx_cnt; i++) begin
                        item = resp;
                        item.kind = ugfrx_pkg::KIND_RX;
                        item.out_byte = rx_mem[i];
                        item.frame_last = (i == rx_cnt - 1);
                        burst.push_back(item);
                    end
                    rx_cnt = 0;
                    rx_phase = ugfrx_pkg::RX_PROC;
                end
            end
            ugfrx_pkg::OP_TX_LOAD: begin
                if (!tx_active) begin
                    if (tx_wr < TX_DEPTH) begin
                        tx_mem[tx_wr] = b;
                        tx_wr++;
                    end
                    if (last) begin
                        tx_total = tx_wr;
                        tx_wr = 0;
                        tx_active = 1'b1;
                        tx_rd = 1;
                        resp.kind = ugfrx_pkg::KIND_TX;
                        resp.out_byte = tx_mem[0];
                    end
                end
            end
            ugfrx_pkg::OP_TX_READY: begin
                if (tx_active) begin
                    if (tx_rd < tx_total) begin
                        resp.kind = ugfrx_pkg::KIND_TX;
                        resp.out_byte = tx_mem[tx_rd];
                        tx_rd++;
                    end else begin
                        tx_active = 1'b0;
                        tx_rd = 1;
                    end
                end
            end
            default: ;
        endcase
        if (burst.size() == 0) burst.push_back(resp);
        foreach (burst[j]) begin
            item = burst[j];
            item.rx_state = rx_phase;
            item.tx_busy = tx_active;
            item.rx_length = rx_cnt[LEN_W-1:0];
            due_responses.push_back(item);
        end
    endfunction

    task automatic stop_offer();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_word(input logic [2:0] op, input logic [7:0] data, input logic last,
                             input bit pinned = 1'b0, input t_response pinned_resp = '0);
        if (burst_left == 0) begin
            stop_offer();
            repeat ($urandom_range(0, 4)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_data_byte <= data;
        i_load_last <= last;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        derive_responses(op, data, last);
        if (pinned) begin
            void'(due_responses.pop_back());
            due_responses.push_back(pinned_resp);
        end
        burst_left--;
    endtask

    task automatic wait_all_responses();
        stop_offer();
        while (due_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_gap_limit(input logic [7:0] value);
        wait_all_responses();
        repeat (IDLE_PAD) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_GAP;
        pwdata <= {{(PDATA_W-8){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        gap_limit = value;
        // read it back right away
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(PDATA_W-8){1'b0}}, value}) begin
            flag_mismatch($sformatf("gap limit read back %0h, expected %0h", prdata, value));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int goal;
        int pick;
        int n;
        int k;
        goal = words_sent + count;
        while (words_sent < goal) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                // receive frame: bytes, then silence that mostly closes the frame, then mostly a release
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) begin
                    send_word(ugfrx_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 4) == 0) begin
                        send_word(ugfrx_pkg::OP_TICK, 8'($urandom), 1'b0);
                    end
                end
                n = int'(gap_limit) + 2 - (($urandom_range(0, 5) == 0) ? 1 : 0);
                repeat (n) send_word(ugfrx_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom));
                if ($urandom_range(0, 7) != 0) begin
                    send_word(ugfrx_pkg::OP_RELEASE, 8'($urandom), 1'b0);
                end
            end else if (pick <= 6) begin
                // transmit frame: loads closed by a last mark, then ready events
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    send_word(ugfrx_pkg::OP_TX_LOAD, 8'($urandom_range(0, 255)), k == n - 1);
                end
                repeat (n - 1 + $urandom_range(0, 2)) begin
                    send_word(ugfrx_pkg::OP_TX_READY, 8'($urandom), 1'b0);
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        gap_limit = ugfrx_pkg::GAP_RESET;
        rx_cnt = 0;
        rx_phase = ugfrx_pkg::RX_IDLE;
        quiet_ticks = 8'd0;
        tx_wr = 0;
        tx_total = 0;
        tx_rd = 0;
        tx_active = 1'b0;
        foreach (rx_mem[i]) rx_mem[i] = 8'd0;
        foreach (tx_mem[i]) tx_mem[i] = 8'd0;
    end

    // output side: stall styles picked at random, long hold on request
    initial begin
        int left;
        int beat;
        t_stall_style style;
        left = 0;
        beat = 0;
        style = ST_OPEN;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            if (left == 0) begin
                style = t_stall_style'($urandom_range(0, 3));
                left = $urandom_range(8, 64);
            end
            left--;
            beat++;
            case (style)
                ST_OPEN:    i_out_ready <= 1'b1;
                ST_COIN:    i_out_ready <= ($urandom_range(0, 1) == 1);
                ST_CADENCE: i_out_ready <= (beat % 4 != 3);
                default:    i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_kind, o_out_byte, o_frame_last, o_rx_state, o_tx_busy, o_rx_length};
            responses_checked++;
            if (due_responses.size() == 0) begin
                flag_mismatch($sformatf("unexpected word: kind %0d byte %02h last %0b",
                                        seen.kind, seen.out_byte, seen.frame_last));
            end else begin
                owed = due_responses.pop_front();
                if (seen !== owed) begin
                    flag_mismatch($sformatf({"word %0d: expected kind %0d byte %02h last %0b ",
                        "state %0d busy %0b len %0d, got kind %0d byte %02h last %0b ",
                        "state %0d busy %0b len %0d"}, responses_checked,
                        owed.kind, owed.out_byte, owed.frame_last, owed.rx_state,
                        owed.tx_busy, owed.rx_length, seen.kind, seen.out_byte,
                        seen.frame_last, seen.rx_state, seen.tx_busy, seen.rx_length));
                end
            end
        end
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_step_row row;
        int rep;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_operation <= ugfrx_pkg::OP_RX_BYTE;
        i_data_byte <= 8'd0;
        i_load_last <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_GAP;
        pwdata <= '0;

        // idle corner cases, then a short frame at the reset gap limit
        add_row(ugfrx_pkg::OP_TX_READY, 8'h00, 1'b0, 1, 0, 1,
                status_only(ugfrx_pkg::RX_IDLE, 1'b0, 0));
        add_row(ugfrx_pkg::OP_RELEASE, 8'h00, 1'b0, 1, 0, 1,
                status_only(ugfrx_pkg::RX_IDLE, 1'b0, 0));
        add_row(OP_SPARE_5, 8'hFF, 1'b1, 1, 0, 1, status_only(ugfrx_pkg::RX_IDLE, 1'b0, 0));
        add_row(OP_SPARE_6, 8'h00, 1'b0, 1, 0, 1, status_only(ugfrx_pkg::RX_IDLE, 1'b0, 0));
        add_row(OP_SPARE_7, 8'hFF, 1'b1, 1, 0, 1, status_only(ugfrx_pkg::RX_IDLE, 1'b0, 0));
        add_row(ugfrx_pkg::OP_TICK, 8'h00, 1'b0, 1, 0, 1,
                status_only(ugfrx_pkg::RX_IDLE, 1'b0, 0));
        add_row(ugfrx_pkg::OP_RX_BYTE, 8'h00, 1'b0, 1, 0, 1,
                status_only(ugfrx_pkg::RX_BUSY, 1'b0, 1));
        add_row(ugfrx_pkg::OP_RX_BYTE, 8'hFF, 1'b1, 1, 0, 1,
                status_only(ugfrx_pkg::RX_BUSY, 1'b0, 2));
        add_row(ugfrx_pkg::OP_TICK, 8'h00, 1'b0, 7, 0, 0, '0);
        // byte while frame pending is ignored
        add_row(ugfrx_pkg::OP_RX_BYTE, 8'hA5, 1'b0, 1, 0, 1,
                status_only(ugfrx_pkg::RX_DONE, 1'b0, 2));
        add_row(ugfrx_pkg::OP_RELEASE, 8'h00, 1'b0, 1, 0, 0, '0);
        add_row(ugfrx_pkg::OP_TX_LOAD, 8'h12, 1'b0, 1, 0, 0, '0);
        add_row(ugfrx_pkg::OP_TX_LOAD, 8'hFF, 1'b0, 1, 0, 0, '0);
        add_row(ugfrx_pkg::OP_TX_LOAD, 8'h00, 1'b1, 1, 0, 0, '0);
        // load while sending is ignored
        add_row(ugfrx_pkg::OP_TX_LOAD, 8'h77, 1'b1, 1, 0, 0, '0);
        add_row(ugfrx_pkg::OP_TX_READY, 8'h00, 1'b0, 3, 0, 0, '0);
        // receive buffer overflow, then a full-length release
        add_row(ugfrx_pkg::OP_RX_BYTE, 8'h00, 1'b0, 33, 1, 0, '0);
        add_row(ugfrx_pkg::OP_TICK, 8'h00, 1'b0, 7, 0, 0, '0);
        add_row(ugfrx_pkg::OP_RELEASE, 8'h00, 1'b0, 1, 0, 0, '0);
        // transmit buffer overflow, the dropped last mark still starts sending
        add_row(ugfrx_pkg::OP_TX_LOAD, 8'h00, 1'b0, 32, 1, 0, '0);
        add_row(ugfrx_pkg::OP_TX_LOAD, 8'h5A, 1'b1, 1, 0, 0, '0);
        add_row(ugfrx_pkg::OP_TX_READY, 8'h00, 1'b0, 32, 0, 0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[r]) begin
            row = directed_plan[r];
            for (rep = 0; rep < row.reps; rep++) begin
                send_word(row.op, row.rnd ? 8'($urandom_range(0, 255)) : row.data, row.last,
                          row.typed, row.want);
            end
        end

        write_gap_limit(GAP_FLOOR);
        random_traffic(10);
        // output held off while words keep coming
        hold_req = 1'b1;
        random_traffic(8);

        // widest gap: a few ticks must not close the frame
        write_gap_limit(GAP_CEIL);
        repeat (3) send_word(ugfrx_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)), 1'b0);
        repeat (CEIL_TICKS) send_word(ugfrx_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1'b0);
        send_word(ugfrx_pkg::OP_RELEASE, 8'h00, 1'b0);

        write_gap_limit(8'($urandom_range(1, 6)));
        random_traffic(8);
        wait_all_responses();
        random_traffic(6);

        wait_all_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d words, checked %0d responses, gap limits reset, %0d, %0d and %0d",
                 words_sent, responses_checked, GAP_FLOOR, GAP_CEIL, gap_limit);
        $display("included buffer overflows, the widest gap limit and a long output stall");
        if (mismatches == 0 && due_responses.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
